/* rtl/core/zsrd_pkg.sv */
// Shared types, codes and constants of the zebra stripe run detector.
`default_nettype none

package zsrd_pkg;

    localparam int PIX_W      = 8;
    localparam int ACT_W      = 2;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // command queue between classifier and run tracker
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACT_W-1:0] ACT_CENTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LEFT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_DIFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_RUNS = 3'd4;

    localparam logic [PIX_W-1:0] THRESHOLD_RST     = 8'd128;
    localparam logic [LEN_W-1:0] MIN_RUN_LEN_RST   = 6'd3;
    localparam logic [LEN_W-1:0] MAX_RUN_LEN_RST   = 6'd20;
    localparam logic [LEN_W-1:0] MAX_RUN_DIFF_RST  = 6'd10;
    localparam logic [CNT_W-1:0] REQUIRED_RUNS_RST = 5'd5;

    localparam logic [LEN_W-1:0] LEN_MAX           = 6'd63;
    localparam logic [CNT_W-1:0] CNT_MAX           = 5'd31;
    localparam logic [IDX_W-1:0] FIRST_CHECKED_RUN = 5'd2;

    typedef struct packed {
        logic [LEN_W-1:0] min_run_len;
        logic [LEN_W-1:0] max_run_len;
        logic [LEN_W-1:0] max_run_diff;
        logic [CNT_W-1:0] required_runs;
    } cfg_t;

    typedef struct packed {
        logic is_center;
        logic is_left;
        logic is_right;
        logic skip;
        logic white;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic             detected_left;
        logic             detected_right;
        logic             detected;
        logic [IDX_W-1:0] left_runs;
        logic [IDX_W-1:0] right_runs;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/zebra_stripe_run_detector_core.sv */
// Top level of the zebra stripe run detector: config registers, front, queue, back.
`default_nettype none

// Takes one pixel item per clock while in_ready is high: a center pixel opens a test
// point, then left and right scan pixels follow in any order, and the item with last
// set yields one result with both sides' detection flags and run indexes. Sustained
// rate is one item per cycle while results are taken; a side's run is updated per
// pixel, closed and checked on a color change, else extended. An accepted item enters
// a two-entry command queue, from which the back end takes it and registers its
// result; the queue lets input flow while a result waits for out_ready, and only an
// item with last set stalls behind an untaken result. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and must only change while the block idles.
module zebra_stripe_run_detector_core #(
    parameter int RUN_SLOTS = 30
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [zsrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [zsrd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [zsrd_pkg::PIX_W-1:0]      pixel,
    input  wire logic [zsrd_pkg::ACT_W-1:0]      action,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 detected_left,
    output logic                                 detected_right,
    output logic                                 detected,
    output logic [zsrd_pkg::IDX_W-1:0]           left_runs,
    output logic [zsrd_pkg::IDX_W-1:0]           right_runs
);

    logic [zsrd_pkg::PIX_W-1:0] threshold_reg;
    zsrd_pkg::cfg_t             cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg         <= zsrd_pkg::THRESHOLD_RST;
            cfg_reg.min_run_len   <= zsrd_pkg::MIN_RUN_LEN_RST;
            cfg_reg.max_run_len   <= zsrd_pkg::MAX_RUN_LEN_RST;
            cfg_reg.max_run_diff  <= zsrd_pkg::MAX_RUN_DIFF_RST;
            cfg_reg.required_runs <= zsrd_pkg::REQUIRED_RUNS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                zsrd_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_data;
                zsrd_pkg::REG_MIN_RUN_LEN:
                    cfg_reg.min_run_len <= cfg_data[zsrd_pkg::LEN_W-1:0];
                zsrd_pkg::REG_MAX_RUN_LEN:
                    cfg_reg.max_run_len <= cfg_data[zsrd_pkg::LEN_W-1:0];
                zsrd_pkg::REG_MAX_RUN_DIFF:
                    cfg_reg.max_run_diff <= cfg_data[zsrd_pkg::LEN_W-1:0];
                zsrd_pkg::REG_REQUIRED_RUNS:
                    cfg_reg.required_runs <= cfg_data[zsrd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    zsrd_pkg::cmd_t front_cmd;
    zsrd_pkg::cmd_t q_cmd;
    zsrd_pkg::res_t res;
    logic           q_full, q_empty;
    logic           q_push, q_pop;
    logic           cmd_ready;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign q_pop    = !q_empty && cmd_ready;

    zsrd_front u_front (
        .pixel     (pixel),
        .action    (action),
        .last      (last),
        .threshold (threshold_reg),
        .cmd       (front_cmd)
    );

    zsrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .empty     (q_empty)
    );

    zsrd_back #(
        .RUN_SLOTS (RUN_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_ready (cmd_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign detected_left  = res.detected_left;
    assign detected_right = res.detected_right;
    assign detected       = res.detected;
    assign left_runs      = res.left_runs;
    assign right_runs     = res.right_runs;

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty at once");

    a_runs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_runs <= zsrd_pkg::IDX_W'(RUN_SLOTS - 1))
                      && (right_runs <= zsrd_pkg::IDX_W'(RUN_SLOTS - 1)))
        else $error("run index beyond last run slot");

    a_both_sides: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && detected) |-> (detected_left && detected_right))
        else $error("crossing flagged without both sides detected");

    a_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !q_empty && q_cmd.last) |-> !q_pop)
        else $error("reporting item taken while result register is held");

endmodule

`default_nettype wire

/* rtl/core/zsrd_front.sv */
// Front end: decodes an input item and classifies its pixel against the threshold.
`default_nettype none

module zsrd_front (
    input  wire logic [zsrd_pkg::PIX_W-1:0] pixel,
    input  wire logic [zsrd_pkg::ACT_W-1:0] action,
    input  wire logic                       last,
    input  wire logic [zsrd_pkg::PIX_W-1:0] threshold,
    output zsrd_pkg::cmd_t                  cmd
);

    always_comb
    begin
        cmd           = '0;
        cmd.white     = (pixel > threshold);
        cmd.skip      = (pixel == threshold);
        cmd.last      = last;
        unique case (action)
            zsrd_pkg::ACT_CENTER: cmd.is_center = 1'b1;
            zsrd_pkg::ACT_LEFT:   cmd.is_left   = 1'b1;
            zsrd_pkg::ACT_RIGHT:  cmd.is_right  = 1'b1;
            default:              ; // unused code: pixel ignored, last still reports
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/zsrd_queue.sv */
// Short command queue between the classifier and the run tracker.
`default_nettype none

module zsrd_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire zsrd_pkg::cmd_t push_data,
    output logic          full,
    input  wire logic     pop,
    output zsrd_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int DEPTH = zsrd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zsrd_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/core/zsrd_back.sv */
// Back end: per-side run tracking, run checks and the result register.
`default_nettype none

module zsrd_back #(
    parameter int RUN_SLOTS = 30
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire zsrd_pkg::cfg_t cfg,
    input  wire logic      cmd_valid,
    input  wire zsrd_pkg::cmd_t cmd,
    output logic           cmd_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output zsrd_pkg::res_t res
);

    localparam logic [zsrd_pkg::IDX_W-1:0] LAST_SLOT = zsrd_pkg::IDX_W'(RUN_SLOTS - 1);

    typedef struct packed {
        logic [zsrd_pkg::IDX_W-1:0] run_index;
        logic [zsrd_pkg::LEN_W-1:0] run_len;
        logic [zsrd_pkg::LEN_W-1:0] closed_len;
        logic [zsrd_pkg::CNT_W-1:0] passed;
        logic                       stopped;
    } side_t;

    function automatic side_t side_step(side_t st, logic white, logic ciw, zsrd_pkg::cfg_t c);
        side_t                      nx;
        logic                       run_white;
        logic                       change;
        logic                       pass;
        logic [zsrd_pkg::LEN_W-1:0] d;
        nx        = st;
        // even runs carry the color opposite to the center
        run_white = st.run_index[0] ? ciw : ~ciw;
        change    = (white != run_white) && (st.run_index < LAST_SLOT);
        d         = (st.closed_len > st.run_len) ? st.closed_len - st.run_len
                                                 : st.run_len - st.closed_len;
        pass      = (st.closed_len >= c.min_run_len) && (st.closed_len < c.max_run_len)
                    && (d < c.max_run_diff);
        if (change)
        begin
            if ((st.run_index > zsrd_pkg::FIRST_CHECKED_RUN) && !st.stopped)
            begin
                if (pass)
                begin
                    if (st.passed < zsrd_pkg::CNT_MAX)
                        nx.passed = st.passed + 1'b1;
                end
                else
                    nx.stopped = 1'b1;
            end
            nx.closed_len = st.run_len;
            nx.run_index  = st.run_index + 1'b1;
            nx.run_len    = zsrd_pkg::LEN_W'(1);
        end
        else if (st.run_len < zsrd_pkg::LEN_MAX)
            nx.run_len = st.run_len + 1'b1;
        return nx;
    endfunction

    side_t          left_reg, left_next;
    side_t          right_reg, right_next;
    logic           ciw_reg, ciw_next;
    logic           out_valid_reg, out_valid_next;
    zsrd_pkg::res_t res_reg, res_next;
    logic           take;
    logic           dl, dr;

    // only an item that reports has to wait for the result register
    assign cmd_ready = !(cmd.last && out_valid_reg && !out_ready);
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        ciw_next   = ciw_reg;
        if (take)
        begin
            if (cmd.is_center)
            begin
                ciw_next   = cmd.white;
                left_next  = '0;
                right_next = '0;
            end
            else if (cmd.is_left && !cmd.skip)
                left_next = side_step(left_reg, cmd.white, ciw_reg, cfg);
            else if (cmd.is_right && !cmd.skip)
                right_next = side_step(right_reg, cmd.white, ciw_reg, cfg);
        end

        dl = (left_next.passed >= cfg.required_runs);
        dr = (right_next.passed >= cfg.required_runs);

        res_next                = res_reg;
        res_next.detected_left  = dl;
        res_next.detected_right = dr;
        res_next.detected       = dl & dr;
        res_next.left_runs      = left_next.run_index;
        res_next.right_runs     = right_next.run_index;

        if (take && cmd.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            ciw_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            ciw_reg       <= ciw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.last)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire
